// ===== hdl/line_fill_justify_buffer_macros.svh =====
// Assertion helpers for the RTL of the line fill buffer.
`ifndef LINE_FILL_JUSTIFY_BUFFER_MACROS_SVH
`define LINE_FILL_JUSTIFY_BUFFER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LFJB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line fill buffer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LFJB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line fill buffer check failed");

`endif

// ===== hdl/lfjb_pkg.sv =====
package lfjb_pkg;

  // Buffer geometry.
  localparam int MAX_WORDS = 32;
  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  // Running sums of widths and gaps over the whole buffer.
  localparam int SUM_W     = CNT_W + 22;
  localparam int DIV_STEPS = 20;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam logic [19:0] MAX20 = 20'hFFFFF;
  localparam logic [15:0] MAX16 = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_WORD    = 3'd0,
    OP_SPACE   = 3'd1,
    OP_NEWLINE = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_FILL    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_SPACE_WIDTH = 3'd0,
    REG_LINE_LENGTH = 3'd1,
    REG_INDENT      = 3'd2,
    REG_FILL_ENABLE = 3'd3,
    REG_JUSTIFY     = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STATUS,
    ST_WALK_RD,
    ST_WALK_EX,
    ST_FIT,
    ST_GAPN_RD,
    ST_GAPN_EX,
    ST_JSTART,
    ST_DIV,
    ST_JUST_RD,
    ST_JUST_EX,
    ST_SUM_RD,
    ST_SUM_EX,
    ST_COMMIT,
    ST_EMIT_RD,
    ST_EMIT_EX
  } state_t;

  // One buffered word.
  typedef struct packed {
    logic [15:0]        width;
    logic [19:0]        gap;
    logic [15:0]        tag;
    logic signed [16:0] below;
    logic [15:0]        above;
  } entry_t;

  // Clamp a running sum to the 20-bit range.
  function automatic logic [19:0] sat20(input logic [SUM_W-1:0] v);
    return (v > SUM_W'(MAX20)) ? MAX20 : v[19:0];
  endfunction

  // Advance a circular buffer pointer by a count of at most MAX_WORDS.
  function automatic logic [IDX_W-1:0] ptr_add(input logic [IDX_W-1:0] p,
                                               input logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
    if (s >= (CNT_W + 1)'(MAX_WORDS)) begin
      s = s - (CNT_W + 1)'(MAX_WORDS);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/line_fill_justify_buffer.sv =====
// Channel  Handshake           Carries
// in       in_valid/in_stall   operation, word, extents, sentence end, temp indent
// out      out_valid/out_stall one emitted word or a status word, with line data
// cfg      cfg_valid/cfg_ready register index and write data, ready always high
//
// Word, space, newline and cancel items pass the status state and may wait for output.
// A fill request walks every buffered word for the fit, reads the first word left
// behind if any, divides the slack by the gap count when justifying, widens the
// inner gaps, sums the line and emits each taken word; in no-fill mode it only
// sums and emits. The word store has one read port and one write port.
// Reset is synchronous; the word store needs no clearing pass.
// A stalled output holds its word; the block takes no new input until done.
`include "line_fill_justify_buffer_macros.svh"

module line_fill_justify_buffer
  import lfjb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [15:0]        in_word_width,
  input  logic [15:0]        in_word_tag,
  input  logic signed [16:0] in_below_extent,
  input  logic [15:0]        in_above_extent,
  input  logic               in_ends_sentence,
  input  logic [19:0]        in_temp_indent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_word_valid,
  output logic [15:0]        out_tag,
  output logic [19:0]        out_gap_before,
  output logic [15:0]        out_width,
  output logic               out_last,
  output logic [19:0]        out_line_width,
  output logic [19:0]        out_line_indent,
  output logic [19:0]        out_line_len_out,
  output logic signed [16:0] out_lowest_extent,
  output logic [15:0]        out_highest_extent,
  output logic               out_flush_needed,
  output logic               out_buffer_empty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  // Configuration registers.
  logic [15:0] space_width_r;
  logic [19:0] line_length_r;
  logic [19:0] indent_r;
  logic        fill_en_r;
  logic        justify_r;

  // Word store.
  entry_t             mem [MAX_WORDS];
  entry_t             rd_data_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               we;
  logic [IDX_W-1:0]   wa;
  entry_t             wd;

  // Sequencer and line state.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [19:0]        total_r, total_nxt;
  logic [19:0]        pgap_r, pgap_nxt;
  logic [15:0]        nl_r, nl_nxt;
  logic               jf_r, jf_nxt;
  logic               se_r, se_nxt;
  logic [19:0]        cur_ind_r, cur_ind_nxt;
  logic [19:0]        cur_len_r, cur_len_nxt;

  // Fill request working registers.
  logic [IDX_W-1:0]   base_r, base_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               plain_r, plain_nxt;
  logic [19:0]        ti_r, ti_nxt;
  logic [19:0]        len_r, len_nxt;
  logic [19:0]        li_r, li_nxt;
  logic [19:0]        ll_r, ll_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               found_r, found_nxt;
  logic [CNT_W-1:0]   fitn_r, fitn_nxt;
  logic [SUM_W-1:0]   fitsum_r, fitsum_nxt;
  logic [SUM_W-1:0]   first_r, first_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [19:0]        rest_total_r, rest_total_nxt;
  entry_t             ent_r, ent_nxt;
  logic [19:0]        dvq_r, dvq_nxt;
  logic [CNT_W:0]     drem_r, drem_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [SUM_W-1:0]   lw_r, lw_nxt;
  logic signed [16:0] lo_r, lo_nxt;
  logic [15:0]        hi_r, hi_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               o_wv_r, o_wv_nxt;
  logic [15:0]        o_tag_r, o_tag_nxt;
  logic [19:0]        o_gap_r, o_gap_nxt;
  logic [15:0]        o_wid_r, o_wid_nxt;
  logic               o_last_r, o_last_nxt;
  logic [19:0]        o_lw_r, o_lw_nxt;
  logic [19:0]        o_li_r, o_li_nxt;
  logic [19:0]        o_ll_r, o_ll_nxt;
  logic signed [16:0] o_lo_r, o_lo_nxt;
  logic [15:0]        o_hi_r, o_hi_nxt;
  logic               o_flush_r, o_flush_nxt;
  logic               o_empty_r, o_empty_nxt;

  // Status terms from the current line state.
  logic [19:0]        avail;
  logic               no_fill_flush;
  logic               st_flush;
  logic               st_empty;
  logic               slot_free;

  assign avail = (cur_len_r > cur_ind_r) ? (cur_len_r - cur_ind_r) : 20'd0;
  assign no_fill_flush = (nl_r > 16'd1) || (nl_r != 16'd0 && pgap_r != 20'd0) ||
                         (nl_r > 16'(jf_r) && count_r == '0);

  always_comb begin
    if (!fill_en_r) begin
      st_flush = nl_r > 16'(jf_r);
      st_empty = !st_flush;
    end else begin
      st_flush = no_fill_flush || (count_r != '0 && total_r > avail);
      st_empty = (count_r == '0) && !no_fill_flush;
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_width_r <= '0;
      line_length_r <= '0;
      indent_r      <= '0;
      fill_en_r     <= 1'b1;
      justify_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SPACE_WIDTH: space_width_r <= cfg_data[15:0];
        REG_LINE_LENGTH: line_length_r <= cfg_data;
        REG_INDENT:      indent_r      <= cfg_data;
        REG_FILL_ENABLE: fill_en_r     <= cfg_data[0];
        REG_JUSTIFY:     justify_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Word store with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer next state and datapath.
  always_comb begin
    logic [19:0]      pg_eff;
    logic [19:0]      g;
    logic [SUM_W-1:0] nsum;
    logic [CNT_W-1:0] n_fit;
    logic [SUM_W-1:0] pre;
    logic [CNT_W:0]   dt;
    logic [CNT_W-1:0] dvsr;
    logic [CNT_W-1:0] rest;
    logic [IDX_W-1:0] new_head;
    entry_t           e;

    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    total_nxt      = total_r;
    pgap_nxt       = pgap_r;
    nl_nxt         = nl_r;
    jf_nxt         = jf_r;
    se_nxt         = se_r;
    cur_ind_nxt    = cur_ind_r;
    cur_len_nxt    = cur_len_r;
    base_nxt       = base_r;
    idx_nxt        = idx_r;
    plain_nxt      = plain_r;
    ti_nxt         = ti_r;
    len_nxt        = len_r;
    li_nxt         = li_r;
    ll_nxt         = ll_r;
    sum_nxt        = sum_r;
    found_nxt      = found_r;
    fitn_nxt       = fitn_r;
    fitsum_nxt     = fitsum_r;
    first_nxt      = first_r;
    n_nxt          = n_r;
    rest_total_nxt = rest_total_r;
    ent_nxt        = ent_r;
    dvq_nxt        = dvq_r;
    drem_nxt       = drem_r;
    dcnt_nxt       = dcnt_r;
    lw_nxt         = lw_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;

    out_valid_nxt  = out_valid_r && out_stall;
    o_wv_nxt       = o_wv_r;
    o_tag_nxt      = o_tag_r;
    o_gap_nxt      = o_gap_r;
    o_wid_nxt      = o_wid_r;
    o_last_nxt     = o_last_r;
    o_lw_nxt       = o_lw_r;
    o_li_nxt       = o_li_r;
    o_ll_nxt       = o_ll_r;
    o_lo_nxt       = o_lo_r;
    o_hi_nxt       = o_hi_r;
    o_flush_nxt    = o_flush_r;
    o_empty_nxt    = o_empty_r;

    we      = 1'b0;
    wa      = head_r;
    wd      = rd_data_r;
    rd_addr = ptr_add(base_r, idx_r);

    pg_eff   = pgap_r;
    g        = '0;
    nsum     = '0;
    n_fit    = '0;
    pre      = '0;
    dt       = '0;
    dvsr     = n_r - CNT_W'(1);
    rest     = count_r - n_r;
    new_head = ptr_add(base_r, n_r);
    e        = rd_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_STATUS;
          li_nxt    = '0;
          ll_nxt    = '0;
          lw_nxt    = '0;
          lo_nxt    = '0;
          hi_nxt    = '0;
          case (op_t'(in_operation))
            OP_WORD: begin
              if (count_r < CNT_W'(MAX_WORDS)) begin
                if (count_r == '0) begin
                  cur_len_nxt = line_length_r;
                  cur_ind_nxt = (in_temp_indent != '0) ? in_temp_indent : indent_r;
                end
                // A newline between words stands for one space, two after a sentence.
                if (nl_r != '0 && pgap_r == '0 && count_r != '0) begin
                  pg_eff = se_r ? 20'({space_width_r, 1'b0}) : 20'(space_width_r);
                end
                g         = jf_r ? 20'd0 : pg_eff;
                we        = 1'b1;
                wa        = ptr_add(head_r, count_r);
                wd        = '{width: in_word_width, gap: g, tag: in_word_tag,
                              below: in_below_extent, above: in_above_extent};
                count_nxt = count_r + CNT_W'(1);
                jf_nxt    = 1'b0;
                total_nxt = sat20(SUM_W'(total_r) + SUM_W'(in_word_width) + SUM_W'(g));
                nl_nxt    = '0;
                pgap_nxt  = '0;
                se_nxt    = in_ends_sentence;
              end
            end
            OP_SPACE: begin
              pgap_nxt = sat20(SUM_W'(pgap_r) + SUM_W'(space_width_r));
            end
            OP_NEWLINE: begin
              if (nl_r != MAX16) begin
                nl_nxt = nl_r + 16'd1;
              end
              pgap_nxt = '0;
            end
            OP_CANCEL: begin
              if (nl_r != '0) begin
                pgap_nxt = sat20(SUM_W'(pgap_r) + SUM_W'(space_width_r));
              end
              nl_nxt = '0;
            end
            OP_FILL: begin
              base_nxt       = head_r;
              idx_nxt        = '0;
              plain_nxt      = !fill_en_r || no_fill_flush;
              ti_nxt         = in_temp_indent;
              len_nxt        = avail;
              li_nxt         = cur_ind_r;
              ll_nxt         = cur_len_r;
              sum_nxt        = '0;
              found_nxt      = 1'b0;
              first_nxt      = '0;
              rest_total_nxt = '0;
              if (!fill_en_r || no_fill_flush) begin
                n_nxt     = count_r;
                state_nxt = (count_r != '0) ? ST_SUM_RD : ST_COMMIT;
              end else begin
                n_nxt     = '0;
                state_nxt = (count_r != '0) ? ST_WALK_RD : ST_COMMIT;
              end
            end
            default: ;
          endcase
        end
      end

      // Status word for items that emit nothing.
      ST_STATUS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_wv_nxt      = 1'b0;
          o_tag_nxt     = '0;
          o_gap_nxt     = '0;
          o_wid_nxt     = '0;
          o_last_nxt    = 1'b1;
          o_lw_nxt      = sat20(lw_r);
          o_li_nxt      = li_r;
          o_ll_nxt      = ll_r;
          o_lo_nxt      = lo_r;
          o_hi_nxt      = hi_r;
          o_flush_nxt   = st_flush;
          o_empty_nxt   = st_empty;
          state_nxt     = ST_IDLE;
        end
      end

      // Greedy fit walk over all buffered words.
      ST_WALK_RD: state_nxt = ST_WALK_EX;
      ST_WALK_EX: begin
        nsum = sum_r + SUM_W'(e.width) + SUM_W'(e.gap);
        if (!found_r && nsum > SUM_W'(len_r)) begin
          found_nxt  = 1'b1;
          fitn_nxt   = idx_r;
          fitsum_nxt = sum_r;
        end
        if (idx_r == '0) begin
          first_nxt = nsum;
        end
        sum_nxt = nsum;
        if (idx_r + CNT_W'(1) == count_r) begin
          state_nxt = ST_FIT;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_WALK_RD;
        end
      end

      // Settle the word count; at least one word goes out.
      ST_FIT: begin
        n_fit = found_r ? fitn_r : count_r;
        pre   = found_r ? fitsum_r : sum_r;
        if (n_fit == '0) begin
          n_fit = CNT_W'(1);
          pre   = first_r;
        end
        n_nxt      = n_fit;
        fitsum_nxt = pre;
        idx_nxt    = n_fit;
        state_nxt  = (n_fit < count_r) ? ST_GAPN_RD : ST_JSTART;
      end

      // First word left behind: its gap drops and the rest is re-totaled.
      ST_GAPN_RD: state_nxt = ST_GAPN_EX;
      ST_GAPN_EX: begin
        ent_nxt        = e;
        rest_total_nxt = sat20(sum_r - fitsum_r - SUM_W'(e.gap));
        state_nxt      = ST_JSTART;
      end

      ST_JSTART: begin
        idx_nxt = '0;
        if (justify_r && n_r > CNT_W'(1)) begin
          dvq_nxt   = (SUM_W'(len_r) > fitsum_r) ? (len_r - fitsum_r[19:0]) : 20'd0;
          drem_nxt  = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_SUM_RD;
        end
      end

      // Restoring division of the slack by the gap count, one bit a cycle.
      ST_DIV: begin
        dt = {drem_r[CNT_W-1:0], dvq_r[19]};
        if (dt >= {1'b0, dvsr}) begin
          drem_nxt = dt - {1'b0, dvsr};
          dvq_nxt  = {dvq_r[18:0], 1'b1};
        end else begin
          drem_nxt = dt;
          dvq_nxt  = {dvq_r[18:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_JUST_RD;
        end
      end

      // Widen each inner gap; the first gaps take one unit of the remainder.
      ST_JUST_RD: begin
        rd_addr   = ptr_add(base_r, idx_r + CNT_W'(1));
        state_nxt = ST_JUST_EX;
      end
      ST_JUST_EX: begin
        rd_addr = ptr_add(base_r, idx_r + CNT_W'(1));
        we      = 1'b1;
        wa      = rd_addr;
        wd      = e;
        wd.gap  = sat20(SUM_W'(e.gap) + SUM_W'(dvq_r) +
                        SUM_W'({1'b0, idx_r} < drem_r));
        if (idx_r + CNT_W'(2) == n_r) begin
          idx_nxt   = '0;
          state_nxt = ST_SUM_RD;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_JUST_RD;
        end
      end

      // Line width and extents over the words going out.
      ST_SUM_RD: state_nxt = ST_SUM_EX;
      ST_SUM_EX: begin
        lw_nxt = lw_r + SUM_W'(e.width) + SUM_W'(e.gap);
        if ($signed(e.below) < lo_r) begin
          lo_nxt = e.below;
        end
        if (e.above > hi_r) begin
          hi_nxt = e.above;
        end
        if (idx_r + CNT_W'(1) == n_r) begin
          state_nxt = ST_COMMIT;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_SUM_RD;
        end
      end

      // Drop the taken words and update the line state before emitting.
      ST_COMMIT: begin
        head_nxt  = new_head;
        count_nxt = rest;
        total_nxt = rest_total_r;
        idx_nxt   = '0;
        if (n_r != '0 && rest != '0) begin
          cur_len_nxt = line_length_r;
          cur_ind_nxt = (ti_r != '0) ? ti_r : indent_r;
        end
        if (plain_r) begin
          jf_nxt = 1'b0;
          if (nl_r != '0) begin
            nl_nxt = nl_r - 16'd1;
          end
        end else begin
          if (rest != '0) begin
            we     = 1'b1;
            wa     = new_head;
            wd     = ent_r;
            wd.gap = '0;
          end
          jf_nxt = (n_r != '0) && (rest == '0);
        end
        state_nxt = (n_r != '0) ? ST_EMIT_RD : ST_STATUS;
      end

      // One result word per taken word.
      ST_EMIT_RD: state_nxt = ST_EMIT_EX;
      ST_EMIT_EX: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_wv_nxt      = 1'b1;
          o_tag_nxt     = e.tag;
          o_gap_nxt     = e.gap;
          o_wid_nxt     = e.width;
          o_last_nxt    = (idx_r + CNT_W'(1) == n_r);
          o_lw_nxt      = sat20(lw_r);
          o_li_nxt      = li_r;
          o_ll_nxt      = ll_r;
          o_lo_nxt      = lo_r;
          o_hi_nxt      = hi_r;
          o_flush_nxt   = st_flush;
          o_empty_nxt   = st_empty;
          if (idx_r + CNT_W'(1) == n_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      total_r     <= '0;
      pgap_r      <= '0;
      nl_r        <= '0;
      jf_r        <= 1'b0;
      se_r        <= 1'b0;
      cur_ind_r   <= '0;
      cur_len_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      pgap_r      <= pgap_nxt;
      nl_r        <= nl_nxt;
      jf_r        <= jf_nxt;
      se_r        <= se_nxt;
      cur_ind_r   <= cur_ind_nxt;
      cur_len_r   <= cur_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    idx_r        <= idx_nxt;
    plain_r      <= plain_nxt;
    ti_r         <= ti_nxt;
    len_r        <= len_nxt;
    li_r         <= li_nxt;
    ll_r         <= ll_nxt;
    sum_r        <= sum_nxt;
    found_r      <= found_nxt;
    fitn_r       <= fitn_nxt;
    fitsum_r     <= fitsum_nxt;
    first_r      <= first_nxt;
    n_r          <= n_nxt;
    rest_total_r <= rest_total_nxt;
    ent_r        <= ent_nxt;
    dvq_r        <= dvq_nxt;
    drem_r       <= drem_nxt;
    dcnt_r       <= dcnt_nxt;
    lw_r         <= lw_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    o_wv_r       <= o_wv_nxt;
    o_tag_r      <= o_tag_nxt;
    o_gap_r      <= o_gap_nxt;
    o_wid_r      <= o_wid_nxt;
    o_last_r     <= o_last_nxt;
    o_lw_r       <= o_lw_nxt;
    o_li_r       <= o_li_nxt;
    o_ll_r       <= o_ll_nxt;
    o_lo_r       <= o_lo_nxt;
    o_hi_r       <= o_hi_nxt;
    o_flush_r    <= o_flush_nxt;
    o_empty_r    <= o_empty_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_word_valid     = o_wv_r;
  assign out_tag            = o_tag_r;
  assign out_gap_before     = o_gap_r;
  assign out_width          = o_wid_r;
  assign out_last           = o_last_r;
  assign out_line_width     = o_lw_r;
  assign out_line_indent    = o_li_r;
  assign out_line_len_out   = o_ll_r;
  assign out_lowest_extent  = o_lo_r;
  assign out_highest_extent = o_hi_r;
  assign out_flush_needed   = o_flush_r;
  assign out_buffer_empty   = o_empty_r;

  // Checks on the sequencer.
  `LFJB_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_WORDS))
  `LFJB_ASSERT_IMPL(a_div_needs_gaps, state_r == ST_DIV, n_r > CNT_W'(1))
  `LFJB_ASSERT_NEXT(a_busy_after_accept, in_valid && state_r == ST_IDLE, state_r != ST_IDLE)
  `LFJB_ASSERT_IMPL(a_emit_in_range, state_r == ST_EMIT_EX, idx_r < n_r)

endmodule
